/* design/sab_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_pkg
// shared types, constants and codes for the suffix array builder
// ----------------------------------------------------------------------------
`default_nettype none

package sab_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ALPHABET  = 27;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int SYM_W     = 5;
    localparam int CNT_DEPTH = (MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);

    localparam logic [SYM_W-1:0] TERMINATOR = '0;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [SYM_W-1:0] symbol;
        logic             is_last;
        logic [9:0]       rank;
    } t_in_item;

    typedef struct packed {
        logic [9:0] suffix_start;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_TERM,
        PH_CLR,
        PH_HIST,
        PH_PREFIX,
        PH_SCATTER,
        PH_COPY_ORD,
        PH_CLASS,
        PH_COPY_CLS,
        PH_DBL,
        PH_CHECK,
        PH_FIN
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   first;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic more;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/suffix_array_builder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_array_builder
// suffix array of a letter text by prefix doubling with counting sorts
//
//   port group        dir  handshake            payload
//   request           in   start / busy         i_in  (t_in_item)
//   result            out  o_valid strobe       o_out (t_out_item)
//
// loads and reads are taken one per cycle while busy is low; a read answers
// in the cycle after its transfer, loads give no result.
// the load marked last raises busy for the build: a symbol pass, then
// ceil(log2 n) doubling rounds and a finish step, n = text length with
// terminator.
// synchronous active-low reset clears control state; memories are not cleared.
// results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_array_builder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sab_pkg::t_in_item i_in,
    output logic                   o_valid,
    output sab_pkg::t_out_item     o_out
);
    import sab_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     accept, load_acc, read_acc, load_last;

    assign accept    = start && !busy;
    assign load_acc  = accept && (i_in.req_type == REQ_LOAD);
    assign read_acc  = accept && (i_in.req_type == REQ_READ);
    assign load_last = load_acc && i_in.is_last;

    sab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_last (load_last),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    sab_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_load   (load_acc),
        .i_read   (read_acc),
        .i_item   (i_in),
        .o_stat   (stat),
        .o_result (o_out),
        .o_valid  (o_valid)
    );

    // a result only follows a read transfer
    a_valid_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(read_acc))
        else $error("result without read transfer");

    // the last letter always starts a build
    a_last_starts_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_last |=> busy)
        else $error("build did not start");

    // no build pass runs while the block is idle
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (cmd.phase == PH_IDLE))
        else $error("pass active while idle");

endmodule

`default_nettype wire

/* design/sab_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_ctrl
// build sequencer: steps the datapath through the counting sort passes
// ----------------------------------------------------------------------------
`default_nettype none

module sab_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load_last,
    input  wire sab_pkg::t_dp_stat i_stat,
    output sab_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);
    import sab_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM,
        S_CLR,
        S_HIST,
        S_PREFIX,
        S_SCATTER,
        S_COPY_ORD,
        S_CLASS,
        S_COPY_CLS,
        S_DBL,
        S_CHECK,
        S_FIN
    } t_state;

    t_state  r_state, n_state;
    t_dp_cmd r_cmd;
    logic    r_busy;

    function automatic t_phase f_phase(input t_state s);
        t_phase p;
        unique case (s)
            S_IDLE:     p = PH_IDLE;
            S_TERM:     p = PH_TERM;
            S_CLR:      p = PH_CLR;
            S_HIST:     p = PH_HIST;
            S_PREFIX:   p = PH_PREFIX;
            S_SCATTER:  p = PH_SCATTER;
            S_COPY_ORD: p = PH_COPY_ORD;
            S_CLASS:    p = PH_CLASS;
            S_COPY_CLS: p = PH_COPY_CLS;
            S_DBL:      p = PH_DBL;
            S_CHECK:    p = PH_CHECK;
            S_FIN:      p = PH_FIN;
            default:    p = PH_IDLE;
        endcase
        return p;
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_load_last) n_state = S_TERM;
            S_TERM:     n_state = S_CLR;
            S_CLR:      if (i_stat.done) n_state = S_HIST;
            S_HIST:     if (i_stat.done) n_state = S_PREFIX;
            S_PREFIX:   if (i_stat.done) n_state = S_SCATTER;
            S_SCATTER:  if (i_stat.done) n_state = r_cmd.first ? S_CLASS : S_COPY_ORD;
            S_COPY_ORD: if (i_stat.done) n_state = S_CLASS;
            S_CLASS:    if (i_stat.done) n_state = r_cmd.first ? S_CHECK : S_COPY_CLS;
            S_COPY_CLS: if (i_stat.done) n_state = S_DBL;
            S_DBL:      n_state = S_CHECK;
            S_CHECK:    n_state = i_stat.more ? S_CLR : S_FIN;
            S_FIN:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd.phase <= PH_IDLE;
            r_cmd.first <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd.phase <= f_phase(n_state);
            r_busy      <= (n_state != S_IDLE);
            // first pass sorts on symbols, later rounds on class pairs
            if (r_state == S_IDLE && i_load_last) begin
                r_cmd.first <= 1'b1;
            end else if (r_state == S_CHECK) begin
                r_cmd.first <= 1'b0;
            end
        end
    end

    assign o_cmd  = r_cmd;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

/* design/sab_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sab_dp
// text, order, class and count memories with the element walkers of each pass
// ----------------------------------------------------------------------------
`default_nettype none

module sab_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sab_pkg::t_dp_cmd  i_cmd,
    input  wire logic              i_load,
    input  wire logic              i_read,
    input  wire sab_pkg::t_in_item i_item,
    output sab_pkg::t_dp_stat      o_stat,
    output sab_pkg::t_out_item     o_result,
    output logic                   o_valid
);
    import sab_pkg::*;

    localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(MAX_LEN - 1);
    localparam logic [LEN_W-1:0] CNT_LIM   = LEN_W'(CNT_DEPTH);
    localparam logic [SYM_W-1:0] SYM_SAT   = SYM_W'(ALPHABET - 1);
    localparam logic [SYM_W-1:0] SYM_LIMIT = SYM_W'(ALPHABET - 1);

    // memories
    logic [SYM_W-1:0]  text_mem  [MAX_LEN];
    logic [ADDR_W-1:0] order_mem [MAX_LEN];
    logic [ADDR_W-1:0] class_mem [MAX_LEN];
    logic [ADDR_W-1:0] nord_mem  [MAX_LEN];
    logic [ADDR_W-1:0] ncls_mem  [MAX_LEN];
    logic [LEN_W-1:0]  count_mem [CNT_DEPTH];

    logic [SYM_W-1:0]  r_txt_q;
    logic [ADDR_W-1:0] r_ord_q, r_cls_q, r_nord_q, r_ncls_q;
    logic [LEN_W-1:0]  r_cnt_q;

    logic              txt_re, ord_re, cls_re, nord_re, ncls_re, cnt_re;
    logic [ADDR_W-1:0] txt_ra, ord_ra, cls_ra, nord_ra, ncls_ra;
    logic [CNT_AW-1:0] cnt_ra;
    logic              txt_we, ord_we, cls_we, nord_we, ncls_we, cnt_we;
    logic [ADDR_W-1:0] txt_wa, ord_wa, cls_wa, nord_wa, ncls_wa;
    logic [CNT_AW-1:0] cnt_wa;
    logic [SYM_W-1:0]  txt_wd;
    logic [ADDR_W-1:0] ord_wd, cls_wd, nord_wd, ncls_wd;
    logic [LEN_W-1:0]  cnt_wd;

    // walker state
    logic [LEN_W-1:0]  r_idx;
    logic [1:0]        r_step;
    logic [LEN_W-1:0]  r_acc;
    logic [ADDR_W-1:0] r_key, r_pos, r_cur, r_cur2, r_k1, r_pk1, r_pk2, r_run;

    // block state
    logic [LEN_W-1:0]  r_len, r_shift;
    logic              r_built, r_ovf;

    logic              r_valid;
    logic [1:0]        r_rd_stat;

    logic [1:0]        last_step;
    logic [LEN_W-1:0]  lim;
    logic              elem_end, done;
    logic [LEN_W-1:0]  down_full;
    logic [ADDR_W-1:0] down_idx;
    logic [ADDR_W-1:0] start_pos, cur2_pos, hist_key, scat_key, run_next;
    logic [LEN_W-1:0]  cnt_dec;
    logic              differs;
    logic [SYM_W-1:0]  sym_in;

    function automatic logic [ADDR_W-1:0] f_wrap(input logic [LEN_W:0] v,
                                                 input logic [LEN_W-1:0] n);
        logic [LEN_W:0] w;
        w = (v >= {1'b0, n}) ? (v - {1'b0, n}) : v;
        return w[ADDR_W-1:0];
    endfunction

    always_comb begin
        unique case (i_cmd.phase)
            PH_HIST:                  last_step = 2'd2;
            PH_PREFIX, PH_COPY_ORD,
            PH_COPY_CLS:              last_step = 2'd1;
            PH_SCATTER, PH_CLASS:     last_step = 2'd3;
            default:                  last_step = 2'd0;
        endcase
        unique case (i_cmd.phase)
            PH_CLR, PH_PREFIX:                         lim = CNT_LIM;
            PH_HIST, PH_SCATTER, PH_COPY_ORD,
            PH_CLASS, PH_COPY_CLS:                     lim = r_len;
            default:                                   lim = LEN_W'(1);
        endcase
    end

    assign elem_end  = (r_step == last_step);
    assign done      = elem_end && (r_idx == lim - LEN_W'(1)) && (i_cmd.phase != PH_IDLE);
    assign down_full = r_len - LEN_W'(1) - r_idx;
    assign down_idx  = down_full[ADDR_W-1:0];
    assign start_pos = f_wrap({2'b00, r_ord_q} + {1'b0, r_len} - {1'b0, r_shift}, r_len);
    assign cur2_pos  = f_wrap({2'b00, r_ord_q} + {1'b0, r_shift}, r_len);
    assign hist_key  = i_cmd.first ? ADDR_W'(r_txt_q) : r_cls_q;
    assign scat_key  = i_cmd.first ? ADDR_W'(r_txt_q) : r_cls_q;
    assign cnt_dec   = r_cnt_q - LEN_W'(1);
    assign differs   = (r_k1 != r_pk1) || (!i_cmd.first && (r_cls_q != r_pk2));
    assign run_next  = (r_idx == '0) ? '0 : (r_run + ADDR_W'(differs));
    assign sym_in    = (i_item.symbol >= SYM_LIMIT) ? SYM_SAT : i_item.symbol;

    assign o_stat.done = done || (i_cmd.phase == PH_TERM) || (i_cmd.phase == PH_DBL)
                         || (i_cmd.phase == PH_CHECK) || (i_cmd.phase == PH_FIN);
    assign o_stat.more = (r_shift < r_len);

    // memory port selection per pass and step
    always_comb begin
        txt_re = 1'b0; ord_re = 1'b0; cls_re = 1'b0;
        nord_re = 1'b0; ncls_re = 1'b0; cnt_re = 1'b0;
        txt_ra = '0; ord_ra = '0; cls_ra = '0; nord_ra = '0; ncls_ra = '0; cnt_ra = '0;
        txt_we = 1'b0; ord_we = 1'b0; cls_we = 1'b0;
        nord_we = 1'b0; ncls_we = 1'b0; cnt_we = 1'b0;
        txt_wa = '0; ord_wa = '0; cls_wa = '0; nord_wa = '0; ncls_wa = '0; cnt_wa = '0;
        txt_wd = '0; ord_wd = '0; cls_wd = '0; nord_wd = '0; ncls_wd = '0; cnt_wd = '0;

        if (i_load) begin
            txt_we = r_built || (r_len < LEN_CAP);
            txt_wa = r_built ? '0 : r_len[ADDR_W-1:0];
            txt_wd = sym_in;
        end
        if (i_read) begin
            ord_re = 1'b1;
            ord_ra = i_item.rank;
        end

        unique case (i_cmd.phase)
            PH_TERM: begin
                txt_we = 1'b1;
                txt_wa = r_len[ADDR_W-1:0];
                txt_wd = TERMINATOR;
            end
            PH_CLR: begin
                cnt_we = 1'b1;
                cnt_wa = r_idx[CNT_AW-1:0];
                cnt_wd = '0;
            end
            PH_HIST: begin
                unique case (r_step)
                    2'd0: begin
                        txt_re = i_cmd.first;  txt_ra = r_idx[ADDR_W-1:0];
                        cls_re = !i_cmd.first; cls_ra = r_idx[ADDR_W-1:0];
                    end
                    2'd1: begin
                        cnt_re = 1'b1; cnt_ra = CNT_AW'(hist_key);
                    end
                    default: begin
                        cnt_we = 1'b1; cnt_wa = CNT_AW'(r_key);
                        cnt_wd = r_cnt_q + LEN_W'(1);
                    end
                endcase
            end
            PH_PREFIX: begin
                if (r_step == 2'd0) begin
                    cnt_re = 1'b1; cnt_ra = r_idx[CNT_AW-1:0];
                end else begin
                    cnt_we = 1'b1; cnt_wa = r_idx[CNT_AW-1:0];
                    cnt_wd = r_acc + r_cnt_q;
                end
            end
            PH_SCATTER: begin
                unique case (r_step)
                    2'd0: begin
                        txt_re = i_cmd.first;  txt_ra = down_idx;
                        ord_re = !i_cmd.first; ord_ra = down_idx;
                    end
                    2'd1: begin
                        cls_re = !i_cmd.first; cls_ra = start_pos;
                    end
                    2'd2: begin
                        cnt_re = 1'b1; cnt_ra = CNT_AW'(scat_key);
                    end
                    default: begin
                        cnt_we = 1'b1; cnt_wa = CNT_AW'(r_key); cnt_wd = cnt_dec;
                        ord_we = i_cmd.first;  ord_wa = cnt_dec[ADDR_W-1:0];  ord_wd = r_pos;
                        nord_we = !i_cmd.first; nord_wa = cnt_dec[ADDR_W-1:0]; nord_wd = r_pos;
                    end
                endcase
            end
            PH_COPY_ORD: begin
                if (r_step == 2'd0) begin
                    nord_re = 1'b1; nord_ra = r_idx[ADDR_W-1:0];
                end else begin
                    ord_we = 1'b1; ord_wa = r_idx[ADDR_W-1:0]; ord_wd = r_nord_q;
                end
            end
            PH_CLASS: begin
                unique case (r_step)
                    2'd0: begin
                        ord_re = 1'b1; ord_ra = r_idx[ADDR_W-1:0];
                    end
                    2'd1: begin
                        txt_re = i_cmd.first;  txt_ra = r_ord_q;
                        cls_re = !i_cmd.first; cls_ra = r_ord_q;
                    end
                    2'd2: begin
                        cls_re = !i_cmd.first; cls_ra = r_cur2;
                    end
                    default: begin
                        cls_we = i_cmd.first;   cls_wa = r_cur;  cls_wd = run_next;
                        ncls_we = !i_cmd.first; ncls_wa = r_cur; ncls_wd = run_next;
                    end
                endcase
            end
            PH_COPY_CLS: begin
                if (r_step == 2'd0) begin
                    ncls_re = 1'b1; ncls_ra = r_idx[ADDR_W-1:0];
                end else begin
                    cls_we = 1'b1; cls_wa = r_idx[ADDR_W-1:0]; cls_wd = r_ncls_q;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (txt_we)  text_mem[txt_wa]   <= txt_wd;
        if (ord_we)  order_mem[ord_wa]  <= ord_wd;
        if (cls_we)  class_mem[cls_wa]  <= cls_wd;
        if (nord_we) nord_mem[nord_wa]  <= nord_wd;
        if (ncls_we) ncls_mem[ncls_wa]  <= ncls_wd;
        if (cnt_we)  count_mem[cnt_wa]  <= cnt_wd;
        if (txt_re)  r_txt_q  <= text_mem[txt_ra];
        if (ord_re)  r_ord_q  <= order_mem[ord_ra];
        if (cls_re)  r_cls_q  <= class_mem[cls_ra];
        if (nord_re) r_nord_q <= nord_mem[nord_ra];
        if (ncls_re) r_ncls_q <= ncls_mem[ncls_ra];
        if (cnt_re)  r_cnt_q  <= count_mem[cnt_ra];
    end

    // per-element scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.phase == PH_HIST && r_step == 2'd1) r_key <= hist_key;
        if (i_cmd.phase == PH_SCATTER) begin
            if (r_step == 2'd1) r_pos <= i_cmd.first ? down_idx : start_pos;
            if (r_step == 2'd2) r_key <= scat_key;
        end
        if (i_cmd.phase == PH_PREFIX && r_step == 2'd1) r_acc <= r_acc + r_cnt_q;
        if (i_cmd.phase == PH_CLR) r_acc <= '0;
        if (i_cmd.phase == PH_CLASS) begin
            if (r_step == 2'd1) begin
                r_cur  <= r_ord_q;
                r_cur2 <= cur2_pos;
            end
            if (r_step == 2'd2) r_k1 <= i_cmd.first ? ADDR_W'(r_txt_q) : r_cls_q;
            if (r_step == 2'd3) begin
                r_run <= run_next;
                r_pk1 <= r_k1;
                r_pk2 <= r_cls_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_step    <= '0;
            r_len     <= '0;
            r_shift   <= LEN_W'(1);
            r_built   <= 1'b0;
            r_ovf     <= 1'b0;
            r_valid   <= 1'b0;
            r_rd_stat <= ST_OK;
        end else begin
            if (done || i_cmd.phase == PH_IDLE) begin
                r_idx  <= '0;
                r_step <= '0;
            end else if (elem_end) begin
                r_idx  <= r_idx + LEN_W'(1);
                r_step <= '0;
            end else begin
                r_step <= r_step + 2'd1;
            end

            if (i_load) begin
                if (r_built) begin
                    // a load after a build starts a new text
                    r_len   <= LEN_W'(1);
                    r_built <= 1'b0;
                    r_ovf   <= 1'b0;
                    r_shift <= LEN_W'(1);
                end else if (r_len < LEN_CAP) begin
                    r_len <= r_len + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.phase == PH_TERM) r_len   <= r_len + LEN_W'(1);
            if (i_cmd.phase == PH_DBL)  r_shift <= {r_shift[LEN_W-2:0], 1'b0};
            if (i_cmd.phase == PH_FIN)  r_built <= 1'b1;

            r_valid <= i_read;
            if (i_read) begin
                priority if (!r_built) begin
                    r_rd_stat <= ST_NOT_BUILT;
                end else if ({1'b0, i_item.rank} >= r_len) begin
                    r_rd_stat <= ST_RANGE;
                end else begin
                    r_rd_stat <= r_ovf ? ST_OVERFLOW : ST_OK;
                end
            end
        end
    end

    assign o_valid                = r_valid;
    assign o_result.status        = r_rd_stat;
    assign o_result.suffix_start  = (r_rd_stat == ST_OK || r_rd_stat == ST_OVERFLOW)
                                    ? r_ord_q : '0;

endmodule

`default_nettype wire
